/* rtl/core/dle_stuffed_command_framer_core_defines.svh */
// Assertion macros for the framer core.
`ifndef DLE_STUFFED_COMMAND_FRAMER_CORE_DEFINES_SVH
`define DLE_STUFFED_COMMAND_FRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define DSCF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dscf assertion failed");
`define DSCF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dscf assertion failed");
`else
`define DSCF_ASSERT_IMP(lbl, ante, cons)
`define DSCF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/dscf_pkg.sv */
package dscf_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PAYLOAD_MAX = 6;
  localparam int unsigned IDX_W       = $clog2(PAYLOAD_MAX);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [3:0] NIBBLE_MASK = 4'hf;

  localparam logic [BYTE_W-1:0] RST_START_CODE  = 8'd2;
  localparam logic [BYTE_W-1:0] RST_END_CODE    = 8'd3;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE = 8'd16;
  localparam logic [BYTE_W-1:0] RST_LONG_CMD    = 8'd1;
  localparam logic [BYTE_W-1:0] RST_SHORT_CMD   = 8'd2;
  localparam logic [BYTE_W-1:0] RST_REG_CMD_A   = 8'd3;
  localparam logic [BYTE_W-1:0] RST_REG_CMD_B   = 8'd4;

  // Last payload index for each format (checksum position).
  localparam logic [IDX_W-1:0] LAST_IDX_LONG  = IDX_W'(5);
  localparam logic [IDX_W-1:0] LAST_IDX_SHORT = IDX_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_CODE  = 3'd0,
    CFG_END_CODE    = 3'd1,
    CFG_ESCAPE_CODE = 3'd2,
    CFG_LONG_CMD    = 3'd3,
    CFG_SHORT_CMD   = 3'd4,
    CFG_REG_CMD_A   = 3'd5,
    CFG_REG_CMD_B   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] long_cmd;
    logic [BYTE_W-1:0] short_cmd;
    logic [BYTE_W-1:0] reg_cmd_a;
    logic [BYTE_W-1:0] reg_cmd_b;
  } cmd_codes_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] end_code;
    logic [BYTE_W-1:0] escape_code;
  } frame_codes_t;

  typedef struct packed {
    logic [PAYLOAD_MAX-1:0][BYTE_W-1:0] data;
    logic [IDX_W-1:0]                   last_idx;
  } frame_desc_t;

  function automatic logic [BYTE_W-1:0] pack_pair(input logic [BYTE_W-1:0] lo,
                                                  input logic [BYTE_W-1:0] hi);
    pack_pair = {hi[3:0] & NIBBLE_MASK, lo[3:0] & NIBBLE_MASK};
  endfunction

endpackage

/* rtl/core/dscf_fifo.sv */
module dscf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/core/dscf_front.sv */
module dscf_front (
  input  logic                       in_push,
  input  logic [dscf_pkg::BYTE_W-1:0] in_command,
  input  logic [dscf_pkg::BYTE_W-1:0] in_arg_0,
  input  logic [dscf_pkg::BYTE_W-1:0] in_arg_1,
  input  logic [dscf_pkg::BYTE_W-1:0] in_arg_2,
  input  logic [dscf_pkg::BYTE_W-1:0] in_arg_3,
  input  logic [dscf_pkg::BYTE_W-1:0] in_arg_4,
  input  logic [dscf_pkg::BYTE_W-1:0] in_arg_5,
  input  logic [dscf_pkg::BYTE_W-1:0] in_arg_6,
  input  logic [dscf_pkg::BYTE_W-1:0] in_arg_7,
  input  dscf_pkg::cmd_codes_t       codes,
  input  logic                       q_full,
  output logic                       q_push,
  output dscf_pkg::frame_desc_t      desc
);

  logic                        is_long, is_short, is_reg, known;
  logic [dscf_pkg::BYTE_W-1:0] pk0, pk1, pk2, pk3;
  logic [dscf_pkg::BYTE_W-1:0] b1, b2, sum3, sum5;

  // First match wins: long, short, then register a/b.
  assign is_long  = (in_command == codes.long_cmd);
  assign is_short = !is_long && (in_command == codes.short_cmd);
  assign is_reg   = !is_long && !is_short &&
                    ((in_command == codes.reg_cmd_a) || (in_command == codes.reg_cmd_b));
  assign known    = is_long || is_short || is_reg;

  assign pk0 = dscf_pkg::pack_pair(in_arg_0, in_arg_1);
  assign pk1 = dscf_pkg::pack_pair(in_arg_2, in_arg_3);
  assign pk2 = dscf_pkg::pack_pair(in_arg_4, in_arg_5);
  assign pk3 = dscf_pkg::pack_pair(in_arg_6, in_arg_7);

  assign b1   = is_reg ? in_arg_0 : pk0;
  assign b2   = is_reg ? in_arg_1 : pk1;
  assign sum3 = in_command + b1 + b2;
  assign sum5 = sum3 + pk2 + pk3;

  always_comb begin
    desc.data[0]  = in_command;
    desc.data[1]  = b1;
    desc.data[2]  = b2;
    desc.data[3]  = is_long ? pk2 : sum3;
    desc.data[4]  = is_long ? pk3 : '0;
    desc.data[5]  = is_long ? sum5 : '0;
    desc.last_idx = is_long ? dscf_pkg::LAST_IDX_LONG : dscf_pkg::LAST_IDX_SHORT;
  end

  // Unknown commands are taken and dropped.
  assign q_push = in_push && !q_full && known;

endmodule

/* rtl/core/dscf_back.sv */
module dscf_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dscf_pkg::frame_desc_t       desc,
  input  logic                        desc_valid,
  input  dscf_pkg::frame_codes_t      codes,
  output logic                        q_pop,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic [dscf_pkg::BYTE_W-1:0] out_tx_byte,
  output logic                        out_frame_end
);

  typedef enum logic [1:0] {
    S_START,
    S_DATA,
    S_END
  } state_t;

  state_t                        state_r, state_nxt;
  logic [dscf_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic                          esc_r, esc_nxt;
  logic                          valid_r, valid_nxt;
  logic [dscf_pkg::BYTE_W-1:0]   byte_r, byte_nxt;
  logic                          end_r, end_nxt;
  logic                          advance, special;
  logic [dscf_pkg::BYTE_W-1:0]   cur;

  assign advance = !valid_r || out_pop;
  assign cur     = desc.data[idx_r];
  assign special = (cur == codes.start_code) || (cur == codes.end_code) ||
                   (cur == codes.escape_code);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    esc_nxt   = esc_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    end_nxt   = end_r;
    q_pop     = 1'b0;
    if (advance) begin
      valid_nxt = desc_valid;
      if (desc_valid) begin
        end_nxt = 1'b0;
        unique case (state_r)
          S_START: begin
            byte_nxt  = codes.start_code;
            idx_nxt   = '0;
            esc_nxt   = 1'b0;
            state_nxt = S_DATA;
          end
          S_DATA: begin
            if (special && !esc_r) begin
              byte_nxt = codes.escape_code;
              esc_nxt  = 1'b1;
            end else begin
              byte_nxt = cur;
              esc_nxt  = 1'b0;
              if (idx_r == desc.last_idx) begin
                state_nxt = S_END;
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
          end
          S_END: begin
            byte_nxt  = codes.end_code;
            end_nxt   = 1'b1;
            q_pop     = 1'b1;
            state_nxt = S_START;
          end
          default: begin
            state_nxt = S_START;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_START;
      idx_r   <= '0;
      esc_r   <= 1'b0;
      valid_r <= 1'b0;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      esc_r   <= esc_nxt;
      valid_r <= valid_nxt;
      end_r   <= end_nxt;
    end
    byte_r <= byte_nxt;
  end

  assign out_empty     = !valid_r;
  assign out_tx_byte   = byte_r;
  assign out_frame_end = end_r;

endmodule

/* rtl/core/dle_stuffed_command_framer_core.sv */
// Command framer: each accepted command item becomes one frame of bytes,
// start code, payload (command, packed nibbles or register/value, 8-bit
// checksum) and end code, with an escape byte in front of every payload byte
// that matches the start, end or escape code. Unknown commands are accepted
// and produce nothing. The output runs at one byte per cycle while out_pop
// is held, and a frame is 6 to 14 bytes long (2 + payload bytes + escapes);
// the front end classifies and packs an item in the cycle it arrives and
// parks it in a QUEUE_DEPTH-entry descriptor queue, so new items are taken
// while the serializer is still sending. No clearing pass after reset.
`include "dle_stuffed_command_framer_core_defines.svh"

module dle_stuffed_command_framer_core #(
  parameter int unsigned QUEUE_DEPTH = dscf_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [dscf_pkg::BYTE_W-1:0]   in_command,
  input  logic [dscf_pkg::BYTE_W-1:0]   in_arg_0,
  input  logic [dscf_pkg::BYTE_W-1:0]   in_arg_1,
  input  logic [dscf_pkg::BYTE_W-1:0]   in_arg_2,
  input  logic [dscf_pkg::BYTE_W-1:0]   in_arg_3,
  input  logic [dscf_pkg::BYTE_W-1:0]   in_arg_4,
  input  logic [dscf_pkg::BYTE_W-1:0]   in_arg_5,
  input  logic [dscf_pkg::BYTE_W-1:0]   in_arg_6,
  input  logic [dscf_pkg::BYTE_W-1:0]   in_arg_7,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [dscf_pkg::BYTE_W-1:0]   out_tx_byte,
  output logic                          out_frame_end,
  input  logic                          cfg_we,
  input  logic [dscf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dscf_pkg::BYTE_W-1:0]   cfg_data
);

  logic [dscf_pkg::BYTE_W-1:0] start_code_r, end_code_r, escape_code_r;
  logic [dscf_pkg::BYTE_W-1:0] long_cmd_r, short_cmd_r, reg_cmd_a_r, reg_cmd_b_r;

  dscf_pkg::cmd_codes_t   cmd_codes;
  dscf_pkg::frame_codes_t frame_codes;
  dscf_pkg::frame_desc_t  wr_desc, rd_desc;
  logic                   q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r  <= dscf_pkg::RST_START_CODE;
      end_code_r    <= dscf_pkg::RST_END_CODE;
      escape_code_r <= dscf_pkg::RST_ESCAPE_CODE;
      long_cmd_r    <= dscf_pkg::RST_LONG_CMD;
      short_cmd_r   <= dscf_pkg::RST_SHORT_CMD;
      reg_cmd_a_r   <= dscf_pkg::RST_REG_CMD_A;
      reg_cmd_b_r   <= dscf_pkg::RST_REG_CMD_B;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dscf_pkg::CFG_START_CODE:  start_code_r  <= cfg_data;
        dscf_pkg::CFG_END_CODE:    end_code_r    <= cfg_data;
        dscf_pkg::CFG_ESCAPE_CODE: escape_code_r <= cfg_data;
        dscf_pkg::CFG_LONG_CMD:    long_cmd_r    <= cfg_data;
        dscf_pkg::CFG_SHORT_CMD:   short_cmd_r   <= cfg_data;
        dscf_pkg::CFG_REG_CMD_A:   reg_cmd_a_r   <= cfg_data;
        dscf_pkg::CFG_REG_CMD_B:   reg_cmd_b_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cmd_codes   = '{long_cmd: long_cmd_r, short_cmd: short_cmd_r,
                         reg_cmd_a: reg_cmd_a_r, reg_cmd_b: reg_cmd_b_r};
  assign frame_codes = '{start_code: start_code_r, end_code: end_code_r,
                         escape_code: escape_code_r};

  assign in_full = q_full;

  dscf_front u_front (
    .in_push    (in_push),
    .in_command (in_command),
    .in_arg_0   (in_arg_0),
    .in_arg_1   (in_arg_1),
    .in_arg_2   (in_arg_2),
    .in_arg_3   (in_arg_3),
    .in_arg_4   (in_arg_4),
    .in_arg_5   (in_arg_5),
    .in_arg_6   (in_arg_6),
    .in_arg_7   (in_arg_7),
    .codes      (cmd_codes),
    .q_full     (q_full),
    .q_push     (q_push),
    .desc       (wr_desc)
  );

  dscf_fifo #(
    .WIDTH ($bits(dscf_pkg::frame_desc_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (wr_desc),
    .pop     (q_pop),
    .rd_data (rd_desc),
    .full    (q_full),
    .empty   (q_empty)
  );

  dscf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .desc          (rd_desc),
    .desc_valid    (!q_empty),
    .codes         (frame_codes),
    .q_pop         (q_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_tx_byte   (out_tx_byte),
    .out_frame_end (out_frame_end)
  );

  `DSCF_ASSERT_IMP(a_end_is_end_code, !out_empty && out_frame_end, out_tx_byte == end_code_r)
  `DSCF_ASSERT_IMP(a_no_queue_overflow, q_push, !q_full)
  `DSCF_ASSERT_NXT(a_pop_on_frame_end, q_pop, !out_empty && out_frame_end)

endmodule

/* dv/dle_stuffed_command_framer_core_test.sv */
module dle_stuffed_command_framer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dscf_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam int DRAIN_GAP = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_REQUESTS = 60;

  typedef struct packed {
    logic [dscf_pkg::BYTE_W-1:0]        command;
    logic [7:0][dscf_pkg::BYTE_W-1:0]   arg;
  } cmd_request_t;

  typedef struct packed {
    logic [dscf_pkg::BYTE_W-1:0] tx_byte;
    logic                        frame_end;
  } frame_byte_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_push = 1'b0;
  logic                        in_full;
  logic [dscf_pkg::BYTE_W-1:0] in_command = '0;
  logic [dscf_pkg::BYTE_W-1:0] in_arg_0 = '0;
  logic [dscf_pkg::BYTE_W-1:0] in_arg_1 = '0;
  logic [dscf_pkg::BYTE_W-1:0] in_arg_2 = '0;
  logic [dscf_pkg::BYTE_W-1:0] in_arg_3 = '0;
  logic [dscf_pkg::BYTE_W-1:0] in_arg_4 = '0;
  logic [dscf_pkg::BYTE_W-1:0] in_arg_5 = '0;
  logic [dscf_pkg::BYTE_W-1:0] in_arg_6 = '0;
  logic [dscf_pkg::BYTE_W-1:0] in_arg_7 = '0;
  logic                        out_empty;
  logic                        out_pop = 1'b0;
  logic [dscf_pkg::BYTE_W-1:0] out_tx_byte;
  logic                        out_frame_end;
  logic                           cfg_we = 1'b0;
  logic [dscf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dscf_pkg::BYTE_W-1:0]    cfg_data = '0;

  // framer codes as the block should currently hold them
  logic [dscf_pkg::BYTE_W-1:0] code_reg [0:6];

  frame_byte_t frame_bytes_due [$];

  int mismatches = 0;
  int requests_sent = 0;
  int frames_due = 0;
  int bytes_checked = 0;
  int cfg_writes = 0;
  int pop_hold = 0;
  int sink_stall_left = 0;
  bit sink_stall_en = 1'b1;
  bit src_idle_en = 1'b1;
  int stuck_cycles = 0;
  frame_byte_t due;

  dle_stuffed_command_framer_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_command    (in_command),
    .in_arg_0      (in_arg_0),
    .in_arg_1      (in_arg_1),
    .in_arg_2      (in_arg_2),
    .in_arg_3      (in_arg_3),
    .in_arg_4      (in_arg_4),
    .in_arg_5      (in_arg_5),
    .in_arg_6      (in_arg_6),
    .in_arg_7      (in_arg_7),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_tx_byte   (out_tx_byte),
    .out_frame_end (out_frame_end),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [dscf_pkg::BYTE_W-1:0] nibble_pack(
      logic [dscf_pkg::BYTE_W-1:0] lo, logic [dscf_pkg::BYTE_W-1:0] hi);
    return {hi[3:0], lo[3:0]};
  endfunction

  function automatic bit is_framing_code(logic [dscf_pkg::BYTE_W-1:0] b);
    return b == code_reg[dscf_pkg::CFG_START_CODE] || b == code_reg[dscf_pkg::CFG_END_CODE] ||
           b == code_reg[dscf_pkg::CFG_ESCAPE_CODE];
  endfunction

  // Works out the stuffed frame for one request and queues its bytes.
  function automatic void build_frame(cmd_request_t req);
    logic [dscf_pkg::BYTE_W-1:0] payload [0:5];
    logic [dscf_pkg::BYTE_W-1:0] sum;
    int len;
    int k;
    payload[0] = req.command;
    if (req.command == code_reg[dscf_pkg::CFG_LONG_CMD]) begin
      payload[1] = nibble_pack(req.arg[0], req.arg[1]);
      payload[2] = nibble_pack(req.arg[2], req.arg[3]);
      payload[3] = nibble_pack(req.arg[4], req.arg[5]);
      payload[4] = nibble_pack(req.arg[6], req.arg[7]);
      len = 5;
    end else if (req.command == code_reg[dscf_pkg::CFG_SHORT_CMD]) begin
      payload[1] = nibble_pack(req.arg[0], req.arg[1]);
      payload[2] = nibble_pack(req.arg[2], req.arg[3]);
      len = 3;
    end else if (req.command == code_reg[dscf_pkg::CFG_REG_CMD_A] ||
                 req.command == code_reg[dscf_pkg::CFG_REG_CMD_B]) begin
      payload[1] = req.arg[0];
      payload[2] = req.arg[1];
      len = 3;
    end else begin
      return;
    end
    sum = '0;
    for (k = 0; k < len; k++) sum = sum + payload[k];
    payload[len] = sum;
    len++;
    frames_due++;
    frame_bytes_due.push_back('{code_reg[dscf_pkg::CFG_START_CODE], 1'b0});
    for (k = 0; k < len; k++) begin
      if (is_framing_code(payload[k]))
        frame_bytes_due.push_back('{code_reg[dscf_pkg::CFG_ESCAPE_CODE], 1'b0});
      frame_bytes_due.push_back('{payload[k], 1'b0});
    end
    frame_bytes_due.push_back('{code_reg[dscf_pkg::CFG_END_CODE], 1'b1});
  endfunction

  function automatic logic [dscf_pkg::BYTE_W-1:0] pick_framing_code();
    case ($urandom_range(0, 2))
      0:       return code_reg[dscf_pkg::CFG_START_CODE];
      1:       return code_reg[dscf_pkg::CFG_END_CODE];
      default: return code_reg[dscf_pkg::CFG_ESCAPE_CODE];
    endcase
  endfunction

  function automatic logic [dscf_pkg::BYTE_W-1:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Known commands, or a random command byte for unknown_pct percent of requests,
  // with random content, biased so packed and register bytes often land on a framing code.
  function automatic cmd_request_t random_request(int unknown_pct);
    cmd_request_t req;
    logic [dscf_pkg::BYTE_W-1:0] hit;
    int sel;
    int k;
    sel = $urandom_range(0, 99);
    if (sel < unknown_pct) begin
      req.command = rand_byte();
    end else begin
      case (sel % 4)
        0:       req.command = code_reg[dscf_pkg::CFG_LONG_CMD];
        1:       req.command = code_reg[dscf_pkg::CFG_SHORT_CMD];
        2:       req.command = code_reg[dscf_pkg::CFG_REG_CMD_A];
        default: req.command = code_reg[dscf_pkg::CFG_REG_CMD_B];
      endcase
    end
    for (k = 0; k < 8; k++) req.arg[k] = rand_byte();
    for (k = 0; k < 8; k += 2) begin
      if ($urandom_range(0, 3) == 0) begin
        hit = pick_framing_code();
        req.arg[k][3:0] = hit[3:0];
        req.arg[k+1][3:0] = hit[7:4];
      end
    end
    if ($urandom_range(0, 3) == 0) req.arg[0] = pick_framing_code();
    if ($urandom_range(0, 3) == 0) req.arg[1] = pick_framing_code();
    return req;
  endfunction

  task automatic flag_mismatch(string what, logic [dscf_pkg::BYTE_W-1:0] got,
                               logic [dscf_pkg::BYTE_W-1:0] want);
    $display("%0t: mismatch on %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
    mismatches++;
  endtask

  // Called at a rising edge; returns at or after the edge that takes the request.
  task automatic send_request(cmd_request_t req);
    in_command <= req.command;
    in_arg_0 <= req.arg[0];
    in_arg_1 <= req.arg[1];
    in_arg_2 <= req.arg[2];
    in_arg_3 <= req.arg[3];
    in_arg_4 <= req.arg[4];
    in_arg_5 <= req.arg[5];
    in_arg_6 <= req.arg[6];
    in_arg_7 <= req.arg[7];
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    build_frame(req);
    requests_sent++;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    do @(posedge clk); while (frame_bytes_due.size() != 0);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic cfg_write(logic [dscf_pkg::CFG_IDX_W-1:0] idx,
                           logic [dscf_pkg::BYTE_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= dscf_pkg::CFG_REG_CMD_B) code_reg[idx] = val;
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic load_codes(logic [dscf_pkg::BYTE_W-1:0] start_c,
                            logic [dscf_pkg::BYTE_W-1:0] end_c,
                            logic [dscf_pkg::BYTE_W-1:0] esc_c,
                            logic [dscf_pkg::BYTE_W-1:0] long_c,
                            logic [dscf_pkg::BYTE_W-1:0] short_c,
                            logic [dscf_pkg::BYTE_W-1:0] rega_c,
                            logic [dscf_pkg::BYTE_W-1:0] regb_c);
    cfg_write(dscf_pkg::CFG_START_CODE, start_c);
    cfg_write(dscf_pkg::CFG_END_CODE, end_c);
    cfg_write(dscf_pkg::CFG_ESCAPE_CODE, esc_c);
    cfg_write(dscf_pkg::CFG_LONG_CMD, long_c);
    cfg_write(dscf_pkg::CFG_SHORT_CMD, short_c);
    cfg_write(dscf_pkg::CFG_REG_CMD_A, rega_c);
    cfg_write(dscf_pkg::CFG_REG_CMD_B, regb_c);
  endtask

  task automatic test_reset_codes();
    send_request({dscf_pkg::RST_LONG_CMD, 64'h0});
    send_request({dscf_pkg::RST_LONG_CMD, 64'hffff_ffff_ffff_ffff});
    // packed bytes hit start, end and escape; high nibbles ignored
    send_request({dscf_pkg::RST_LONG_CMD, 64'hf0f0_f1f0_f0f3_f0f2});
    send_request({dscf_pkg::RST_SHORT_CMD, 64'h1234_5678_a55a_5aa5});
    send_request({dscf_pkg::RST_REG_CMD_A, 64'h0000_0000_0000_000d});
    send_request({dscf_pkg::RST_REG_CMD_B, 64'h0000_0000_0000_ffff});
    send_request({dscf_pkg::RST_REG_CMD_A, 64'h0000_0000_0000_0310});
    send_request({dscf_pkg::RST_REG_CMD_B, 64'h0000_0000_0000_0002});
    send_request({8'h00, 64'h0});
    send_request({8'hff, 64'hffff_ffff_ffff_ffff});
    send_request({8'h05, 64'h1234_5678_9abc_def0});
    wait_drained();
  endtask

  task automatic test_overlapping_codes();
    // long number wins over every other command sharing its code
    load_codes(8'h7e, 8'h7e, 8'h7e, 8'h55, 8'h55, 8'h55, 8'h55);
    cfg_write(CFG_IDX_UNUSED, 8'h55);
    send_request({8'h55, 64'h0707_0e0e_0707_0e0e});
    send_request({8'h55, 64'h0000_0000_0000_7e7e});
    wait_drained();
    cfg_write(dscf_pkg::CFG_LONG_CMD, 8'h11);
    send_request({8'h55, 64'h0000_0000_0000_7e7e});
    wait_drained();
    cfg_write(CFG_IDX_UNUSED, 8'hff);
    cfg_write(dscf_pkg::CFG_SHORT_CMD, 8'h22);
    send_request({8'h55, 64'h0000_0000_0000_7e7e});
    send_request({8'h22, 64'h0000_0000_0000_e7e7});
    send_request({8'h11, 64'h0000_0000_0000_e7e7});
    wait_drained();
  endtask

  task automatic test_extreme_codes();
    load_codes(8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h80);
    send_request({8'hff, 64'hffff_ffff_0000_0000});
    send_request({8'h00, 64'h0000_0000_0f0f_0f0f});
    send_request({8'h80, 64'h0000_0000_0000_ff00});
    send_request({8'h7f, 64'h0});
    wait_drained();
    load_codes(8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h80, 8'h00);
    send_request({8'h00, 64'h0});
    send_request({8'hff, 64'hffff_ffff_ffff_ffff});
    send_request({8'h80, 64'h0000_0000_0000_00ff});
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0)
        load_codes(dscf_pkg::RST_START_CODE, dscf_pkg::RST_END_CODE,
                   dscf_pkg::RST_ESCAPE_CODE, dscf_pkg::RST_LONG_CMD,
                   dscf_pkg::RST_SHORT_CMD, dscf_pkg::RST_REG_CMD_A,
                   dscf_pkg::RST_REG_CMD_B);
      else
        load_codes(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                   rand_byte(), rand_byte(), rand_byte());
      for (n = 0; n < PHASE_REQUESTS; n++) send_request(random_request(15));
      wait_drained();
    end
  endtask

  task automatic test_receiver_backpressure();
    int n;
    src_idle_en = 1'b0;
    pop_hold = 150;
    for (n = 0; n < 24; n++) send_request(random_request(0));
    wait_drained();
    src_idle_en = 1'b1;
  endtask

  task automatic test_steady_stream();
    int n;
    src_idle_en = 1'b0;
    sink_stall_en = 1'b0;
    load_codes(rand_byte(), rand_byte(), rand_byte(), dscf_pkg::RST_LONG_CMD,
               dscf_pkg::RST_SHORT_CMD, dscf_pkg::RST_REG_CMD_A,
               dscf_pkg::RST_REG_CMD_B);
    for (n = 0; n < 60; n++) send_request(random_request(10));
    wait_drained();
  endtask

  // result side: random stall bursts plus an occasional long hold
  initial begin
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_pop <= 1'b0;
      end else if (pop_hold > 0) begin
        out_pop <= 1'b0;
        pop_hold--;
      end else if (sink_stall_left > 0) begin
        out_pop <= 1'b0;
        sink_stall_left--;
      end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
        out_pop <= 1'b0;
        sink_stall_left = $urandom_range(0, 7);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      bytes_checked++;
      if (frame_bytes_due.size() == 0) begin
        flag_mismatch("byte with no frame pending", out_tx_byte, 8'h00);
      end else begin
        due = frame_bytes_due.pop_front();
        if (out_tx_byte !== due.tx_byte)
          flag_mismatch("tx_byte", out_tx_byte, due.tx_byte);
        if (out_frame_end !== due.frame_end)
          flag_mismatch("frame_end", 8'(out_frame_end), 8'(due.frame_end));
      end
    end
  end

  initial begin
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_push && !in_full) || (out_pop && !out_empty))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("%0t: no request moved for %0d cycles, %0d bytes still due", $time,
             WATCHDOG_LIMIT, frame_bytes_due.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    code_reg[dscf_pkg::CFG_START_CODE] = dscf_pkg::RST_START_CODE;
    code_reg[dscf_pkg::CFG_END_CODE] = dscf_pkg::RST_END_CODE;
    code_reg[dscf_pkg::CFG_ESCAPE_CODE] = dscf_pkg::RST_ESCAPE_CODE;
    code_reg[dscf_pkg::CFG_LONG_CMD] = dscf_pkg::RST_LONG_CMD;
    code_reg[dscf_pkg::CFG_SHORT_CMD] = dscf_pkg::RST_SHORT_CMD;
    code_reg[dscf_pkg::CFG_REG_CMD_A] = dscf_pkg::RST_REG_CMD_A;
    code_reg[dscf_pkg::CFG_REG_CMD_B] = dscf_pkg::RST_REG_CMD_B;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_codes();
    test_overlapping_codes();
    test_extreme_codes();
    test_random_traffic();
    test_receiver_backpressure();
    test_steady_stream();
    $display("Sent %0d commands, %0d framed; %0d bytes checked.", requests_sent,
             frames_due, bytes_checked);
    $display("%0d code writes across reset, overlapping, extreme and random settings.",
             cfg_writes);
    if (mismatches == 0 && frame_bytes_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/dscf_pkg.sv
rtl/core/dscf_fifo.sv
rtl/core/dscf_front.sv
rtl/core/dscf_back.sv
rtl/core/dle_stuffed_command_framer_core.sv
dv/dle_stuffed_command_framer_core_test.sv
